>>> rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg: shared types and constants for the min/max contrast stretcher
// Sample and level widths, sequencer states, divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package mms_pkg;

    // Default sample width, port widths and quotient size
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PIXEL_W         = 16;
    localparam int LEVEL_W         = 8;
    localparam int QUOT_BITS       = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Item commands
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage : mms_pkg

`default_nettype wire

>>> rtl/mms_range.sv
// ----------------------------------------------------------------------------
// mms_range: running minimum and maximum tracker
// Updates the lowest and highest sample on each measure item; restart reloads
// both from the current sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_range import mms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_update,
    input  wire logic                   i_restart,
    input  wire logic [SAMPLE_BITS-1:0] i_px,
    output logic      [SAMPLE_BITS-1:0] o_lowest,
    output logic      [SAMPLE_BITS-1:0] o_highest
);

    logic [SAMPLE_BITS-1:0] r_lowest;
    logic [SAMPLE_BITS-1:0] r_highest;
    logic [SAMPLE_BITS-1:0] n_lowest;
    logic [SAMPLE_BITS-1:0] n_highest;

    // Pick the new bounds for a measured sample
    always_comb begin
        n_lowest  = r_lowest;
        n_highest = r_highest;
        if (i_restart) begin
            n_lowest  = i_px;
            n_highest = i_px;
        end else begin
            if (i_px < r_lowest) begin
                n_lowest = i_px;
            end
            if (i_px > r_highest) begin
                n_highest = i_px;
            end
        end
    end

    // Hold bounds, advance on update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= '1;
            r_highest <= '0;
        end else if (i_update) begin
            r_lowest  <= n_lowest;
            r_highest <= n_highest;
        end
    end

    assign o_lowest  = r_lowest;
    assign o_highest = r_highest;

endmodule : mms_range

`default_nettype wire

>>> rtl/mms_div.sv
// ----------------------------------------------------------------------------
// mms_div: iterative restoring divider
// One trial subtract per cycle, QUOT_BITS steps per quotient. The numerator
// must stay below 2^QUOT_BITS times the denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_div import mms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [SAMPLE_BITS+QUOT_BITS-1:0] i_num,
    input  wire logic [SAMPLE_BITS-1:0]           i_den,
    output t_div_status                           o_status,
    output logic      [QUOT_BITS-1:0]             o_quotient
);

    localparam int NUM_W  = SAMPLE_BITS + QUOT_BITS;
    localparam int STEP_W = $clog2(QUOT_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_BITS - 1);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [QUOT_BITS-1:0]   r_quo;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;

    logic [SAMPLE_BITS:0]   w_part;
    logic [SAMPLE_BITS+1:0] w_diff;
    logic                   w_ge;

    // Shared trial subtract: shift in the next numerator bit, compare to divisor
    assign w_part = {r_rem, r_quo[QUOT_BITS-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, r_den};
    assign w_ge   = ~w_diff[SAMPLE_BITS+1];

    // Control: step counter, busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then restore or keep each step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:QUOT_BITS];
            r_quo <= i_num[QUOT_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SAMPLE_BITS-1:0] : w_part[SAMPLE_BITS-1:0];
            r_quo <= {r_quo[QUOT_BITS-2:0], w_ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

    // Done comes in the cycle after the last step
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finishing step");

    // Remainder stays below the divisor while iterating
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_den || r_den == '0)
        else $error("divider remainder out of range");

endmodule : mms_div

`default_nettype wire

>>> rtl/minmax_stretch_16_to_8.sv
// ----------------------------------------------------------------------------
// minmax_stretch_16_to_8: min/max contrast stretch of samples into bytes
// Measure items track the range; wide-mode converts inside a non-flat
// range map to floor((px - min) * 255 / (max - min)).
// ----------------------------------------------------------------------------
// Sequence: a dividing convert item passes setup, the iterative divider's steps,
//   its done pulse and the output stage; other converts skip the divider.
// Flow: one item at a time; the next is accepted only after the current one is
//   finished, and a convert waits until the output register can take its result.
// Reset: synchronous active low; min = all ones, max = 0, wide mode on.
`default_nettype none

module minmax_stretch_16_to_8 import mms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_wide_samples,
    // input items
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_cmd,
    input  wire logic [PIXEL_W-1:0] i_pixel,
    input  wire logic               i_restart,
    // result items
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [LEVEL_W-1:0] o_level,
    output logic                    o_flat_image
);

    localparam int NUM_W = SAMPLE_BITS + QUOT_BITS;

    t_state                 r_state;
    t_state                 n_state;
    logic                   r_wide;
    logic                   r_cmd;
    logic                   r_restart;
    logic [PIXEL_W-1:0]     r_pixel;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_flat;
    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_out_level;
    logic                   r_out_flat;

    logic [SAMPLE_BITS-1:0] w_px;
    logic [SAMPLE_BITS-1:0] w_lowest;
    logic [SAMPLE_BITS-1:0] w_highest;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic [NUM_W-1:0]       w_num;
    logic [SAMPLE_BITS-1:0] w_den;
    logic                   w_flat_cond;
    logic                   w_below;
    logic                   w_above;
    logic                   w_need_div;
    logic                   w_accept;
    logic                   w_range_upd;
    logic                   w_div_start;
    logic                   w_special;
    logic                   w_emit;
    t_div_status            w_div_status;
    logic [QUOT_BITS-1:0]   w_quotient;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (i_cfg_valid) begin
            r_wide <= i_cfg_wide_samples;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_cmd;
            r_pixel   <= i_pixel;
            r_restart <= i_restart;
        end
    end

    assign w_px = r_pixel[SAMPLE_BITS-1:0];

    mms_range #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_range (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (w_range_upd),
        .i_restart (r_restart),
        .i_px      (w_px),
        .o_lowest  (w_lowest),
        .o_highest (w_highest)
    );

    // Classify the sample and form numerator (diff * 255) and divisor
    assign w_flat_cond = (w_highest <= w_lowest);
    assign w_below     = (w_px < w_lowest);
    assign w_above     = (w_px > w_highest);
    assign w_diff      = w_px - w_lowest;
    assign w_num       = {w_diff, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, w_diff};
    assign w_den       = w_highest - w_lowest;
    assign w_need_div  = r_wide && !w_flat_cond && !w_below && !w_above;

    mms_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_num      (w_num),
        .i_den      (w_den),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (r_cmd == CMD_MEASURE) begin
                    n_state = ST_IDLE;
                end else if (w_need_div) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_range_upd = 1'b0;
        w_div_start = 1'b0;
        w_special   = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            ST_SETUP: begin
                w_range_upd = (r_cmd == CMD_MEASURE);
                w_div_start = (r_cmd == CMD_CONVERT) && w_need_div;
                w_special   = (r_cmd == CMD_CONVERT) && !w_need_div;
            end
            ST_DONE: begin
                w_emit = !r_out_valid || i_ready;
            end
            default: begin
                w_range_upd = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stage the result: special cases in setup, quotient when the divider ends
    always_ff @(posedge i_clk) begin
        if (w_special) begin
            if (!r_wide) begin
                r_level <= r_pixel[LEVEL_W-1:0];
                r_flat  <= 1'b0;
            end else if (w_flat_cond) begin
                r_level <= '0;
                r_flat  <= 1'b1;
            end else if (w_below) begin
                r_level <= '0;
                r_flat  <= 1'b0;
            end else begin
                r_level <= LEVEL_MAX;
                r_flat  <= 1'b0;
            end
        end else if (w_div_status.done) begin
            r_level <= w_quotient;
            r_flat  <= 1'b0;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_level <= r_level;
            r_out_flat  <= r_flat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_level      = r_out_level;
    assign o_flat_image = r_out_flat;

    // A flat image always reports level zero
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flat_image |-> o_level == '0)
        else $error("flat image with nonzero level");

    // The divider only runs while the sequencer waits on it
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.busy |-> r_state == ST_DIV)
        else $error("divider busy outside division state");

    // A measure item never reaches the result stage
    a_measure_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SETUP && r_cmd == CMD_MEASURE |=> r_state == ST_IDLE)
        else $error("measure item did not return to idle");

endmodule : minmax_stretch_16_to_8

`default_nettype wire

>>> test/tb_minmax_stretch_16_to_8.sv
// ----------------------------------------------------------------------------
// tb_minmax_stretch_16_to_8: self-checking bench for the min/max stretcher
// Streams measure and convert items through the valid/ready ports with
// random idling on both sides. A built-in range tracker predicts every level
// and flat flag and compares them in order against the block's results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_minmax_stretch_16_to_8;
    timeunit 1ns;
    timeprecision 1ps;

    import mms_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int unsigned PIX_MASK      = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int          SETTLE_CYCLES = 16;    // longest item latency plus margin
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned N_ITEMS       = 1600;
    localparam int unsigned CALM_AFTER    = 1300;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               flat;
    } t_level;

    // Range tracker and in-order store of levels still owed by the block
    class level_scoreboard;
        bit          wide;
        int unsigned lo_seen;
        int unsigned hi_seen;
        t_level      levels_due[$];
        int unsigned errors;
        int unsigned n_items;
        int unsigned n_levels;
        int unsigned n_flat;
        int unsigned n_sat;
        int unsigned n_cfg;

        function new();
            wide    = 1'b1;
            lo_seen = PIX_MASK;
            hi_seen = 0;
        endfunction

        function void note_config(logic wide_in);
            wide = wide_in;
            n_cfg++;
        endfunction

        function void note_item(logic cmd, logic [PIXEL_W-1:0] pixel, logic restart);
            int unsigned px;
            t_level      due;
            px = pixel & PIX_MASK;
            n_items++;
            // Measure: widen the range, or restart it at this pixel
            if (cmd == CMD_MEASURE) begin
                if (restart) begin
                    lo_seen = px;
                    hi_seen = px;
                end else begin
                    if (px < lo_seen) lo_seen = px;
                    if (px > hi_seen) hi_seen = px;
                end
                return;
            end
            // Convert: pass-through, flat range, saturation or stretch
            due.flat = 1'b0;
            if (!wide) begin
                due.level = pixel[LEVEL_W-1:0];
            end else if (hi_seen <= lo_seen) begin
                due.level = '0;
                due.flat  = 1'b1;
                n_flat++;
            end else if (px < lo_seen) begin
                due.level = '0;
                n_sat++;
            end else if (px > hi_seen) begin
                due.level = LEVEL_MAX;
                n_sat++;
            end else begin
                due.level = LEVEL_W'(((px - lo_seen) * int'(LEVEL_MAX))
                                     / (hi_seen - lo_seen));
            end
            levels_due.push_back(due);
        endfunction

        function void check_level(logic [LEVEL_W-1:0] level, logic flat);
            t_level due;
            if (levels_due.size() == 0) begin
                $display("%0t: unexpected result: level %0d flat %0b", $time, level, flat);
                errors++;
                return;
            end
            due = levels_due.pop_front();
            n_levels++;
            if (level !== due.level) begin
                $display("%0t: level mismatch: expected %0d actual %0d",
                         $time, due.level, level);
                errors++;
            end
            if (flat !== due.flat) begin
                $display("%0t: flat_image mismatch: expected %0b actual %0b",
                         $time, due.flat, flat);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_valid        = 1'b0;
    logic               i_cfg_wide_samples = 1'b1;
    logic               i_valid            = 1'b0;
    logic               i_cmd              = CMD_MEASURE;
    logic [PIXEL_W-1:0] i_pixel            = '0;
    logic               i_restart          = 1'b0;
    logic               i_ready            = 1'b0;
    logic               o_cfg_ready;
    logic               o_ready;
    logic               o_valid;
    logic [LEVEL_W-1:0] o_level;
    logic               o_flat_image;

    level_scoreboard sb = new();
    bit              calm = 1'b0;
    int unsigned     n_sent = 0;
    int unsigned     ready_left = 0;
    int unsigned     quiet = 0;

    minmax_stretch_16_to_8 u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_wide_samples (i_cfg_wide_samples),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_pixel            (i_pixel),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_level            (o_level),
        .o_flat_image       (o_flat_image)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Receiver: random bursts of ready or stall, hold ready high once calm
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            i_ready    <= ($urandom_range(0, 2) != 0);
            ready_left <= $urandom_range(0, 18);
        end
    end

    // Observe every handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.note_config(i_cfg_wide_samples);
            if (i_valid && o_ready) sb.note_item(i_cmd, i_pixel, i_restart);
            if (o_valid && i_ready) sb.check_level(o_level, o_flat_image);
        end
    end

    // Drop the run after too long without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (i_valid && o_ready)
                    || (o_valid && i_ready)) begin
                quiet <= 0;
            end else if (quiet >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("** minmax_stretch_16_to_8: FAILED **");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // Offer one item, with an optional gap in front, and hold it until taken
    task automatic send_item(input logic cmd, input logic [PIXEL_W-1:0] px,
                             input logic restart);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_pixel   <= px;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Drain all owed levels, let the block go idle, then write the register
    task automatic write_config(input logic wide);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.levels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_wide_samples <= wide;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned        span;
        int unsigned        lo;
        int unsigned        hi;
        logic [PIXEL_W-1:0] px;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config(1'b1);

        // Nothing measured yet: flat
        send_item(CMD_CONVERT, 16'h0000, 1'b0);
        send_item(CMD_CONVERT, 16'hFFFF, 1'b1);
        // Single-pixel image: flat, and below range still flat
        send_item(CMD_MEASURE, 16'd1000, 1'b1);
        send_item(CMD_CONVERT, 16'd1000, 1'b0);
        send_item(CMD_CONVERT, 16'd999, 1'b0);
        // Full range
        send_item(CMD_MEASURE, 16'h0000, 1'b0);
        send_item(CMD_MEASURE, 16'hFFFF, 1'b0);
        send_item(CMD_CONVERT, 16'h0000, 1'b0);
        send_item(CMD_CONVERT, 16'hFFFF, 1'b0);
        send_item(CMD_CONVERT, 16'h8000, 1'b0);
        send_item(CMD_CONVERT, 16'h0001, 1'b0);
        send_item(CMD_CONVERT, 16'hFFFE, 1'b0);
        // Narrow range: below, above, both ends, middle
        send_item(CMD_MEASURE, 16'd500, 1'b1);
        send_item(CMD_MEASURE, 16'd700, 1'b0);
        send_item(CMD_CONVERT, 16'd499, 1'b1);
        send_item(CMD_CONVERT, 16'd701, 1'b0);
        send_item(CMD_CONVERT, 16'd500, 1'b0);
        send_item(CMD_CONVERT, 16'd700, 1'b1);
        send_item(CMD_CONVERT, 16'd600, 1'b0);
        // Pass-through, with measures still tracking the range
        write_config(1'b0);
        send_item(CMD_CONVERT, 16'hABCD, 1'b0);
        send_item(CMD_CONVERT, 16'h5432, 1'b1);
        send_item(CMD_MEASURE, 16'h1234, 1'b1);
        send_item(CMD_MEASURE, 16'h1300, 1'b0);
        write_config(1'b1);
        send_item(CMD_CONVERT, 16'h1234, 1'b0);
        send_item(CMD_CONVERT, 16'h1300, 1'b0);
        send_item(CMD_CONVERT, 16'h1299, 1'b0);

        // Random images: measure pass, then convert pass
        while (n_sent < N_ITEMS) begin
            if (n_sent >= CALM_AFTER) calm = 1'b1;
            if ($urandom_range(0, 4) == 0) write_config($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 5))
                0:       span = 0;
                1:       span = 1;
                2:       span = $urandom_range(2, 300);
                3, 4:    span = $urandom_range(2, PIX_MASK);
                default: span = PIX_MASK;
            endcase
            lo = $urandom_range(0, PIX_MASK - span);
            hi = lo + span;
            if ($urandom_range(0, 7) != 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(CMD_MEASURE, PIXEL_W'(lo), 1'b1);
                    send_item(CMD_MEASURE, PIXEL_W'(hi), 1'b0);
                end else begin
                    send_item(CMD_MEASURE, PIXEL_W'(hi), 1'b1);
                    send_item(CMD_MEASURE, PIXEL_W'(lo), 1'b0);
                end
                repeat ($urandom_range(0, 12))
                    send_item(CMD_MEASURE, PIXEL_W'(lo + $urandom_range(0, span)), 1'b0);
            end else begin
                // Broken pass: stray measures, restarts anywhere
                repeat ($urandom_range(1, 6))
                    send_item(CMD_MEASURE, PIXEL_W'($urandom),
                              $urandom_range(0, 3) == 0);
            end
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 10))
                    0:       px = PIXEL_W'($urandom);
                    1:       px = PIXEL_W'((lo == 0) ? lo : lo - 1);
                    2:       px = PIXEL_W'((hi == PIX_MASK) ? hi : hi + 1);
                    3:       px = PIXEL_W'(lo);
                    4:       px = PIXEL_W'(hi);
                    default: px = PIXEL_W'(lo + $urandom_range(0, span));
                endcase
                if ($urandom_range(0, 19) == 0)
                    send_item(CMD_MEASURE, PIXEL_W'($urandom), 1'b0);
                else
                    send_item(CMD_CONVERT, px, 1'($urandom_range(0, 1)));
            end
        end

        // Drain and let the block settle
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.levels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over %0d register writes; checked %0d levels",
                 sb.n_items, sb.n_cfg, sb.n_levels);
        $display("of which %0d on flat images and %0d saturated; %0d errors",
                 sb.n_flat, sb.n_sat, sb.errors);
        if (sb.errors == 0) begin
            $display("** minmax_stretch_16_to_8: PASSED **");
        end else begin
            $display("** minmax_stretch_16_to_8: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/mms_pkg.sv
rtl/mms_range.sv
rtl/mms_div.sv
rtl/minmax_stretch_16_to_8.sv
test/tb_minmax_stretch_16_to_8.sv
